### sv/shadow_bitmap_range_marker_top_assert.svh
// ----------------------------------------------------------------------------
// Shadow bitmap range marker assertion macros
// Implication checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SHADOW_BITMAP_RANGE_MARKER_TOP_ASSERT_SVH
`define SHADOW_BITMAP_RANGE_MARKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SBRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sbrm_pkg.sv
// ----------------------------------------------------------------------------
// Shadow bitmap range marker package
// Sizes of the tracked range and the shadow store, and the memory port type.
// ----------------------------------------------------------------------------
`default_nettype none

package sbrm_pkg;

  localparam int unsigned TRACKED_BYTES = 32'h0010_0000;
  localparam int unsigned SHADOW_DEPTH  = (TRACKED_BYTES + 7) / 8;
  localparam int unsigned ADDR_W        = 20;
  localparam int unsigned IDX_W         = $clog2(SHADOW_DEPTH);
  localparam int unsigned LEN_W         = 7;
  localparam int unsigned BYTE_W        = 8;

  localparam logic [LEN_W-1:0] MAX_RUN  = LEN_W'(64);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SHADOW_DEPTH - 1);

  localparam logic OP_MARK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

`default_nettype wire

### sv/sbrm_shadow_mem.sv
// ----------------------------------------------------------------------------
// Shadow bitmap store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrm_shadow_mem (
  input  wire                         clk,
  input  wire sbrm_pkg::mem_req_t     req,
  output logic [sbrm_pkg::BYTE_W-1:0] rdata
);
  import sbrm_pkg::*;

  logic [BYTE_W-1:0] mem [SHADOW_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

### sv/sbrm_ctrl.sv
// ----------------------------------------------------------------------------
// Shadow bitmap range marker controller
// Clears the store after reset, then walks each run one shadow byte at a time:
// read, update one bit per cycle while the output accepts results, with a result word each, and write back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shadow_bitmap_range_marker_top_assert.svh"

module sbrm_ctrl (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         req_type,
  input  wire [sbrm_pkg::ADDR_W-1:0]  start_address,
  input  wire [sbrm_pkg::LEN_W-1:0]   run_length,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [sbrm_pkg::IDX_W-1:0]  shadow_index,
  output logic [sbrm_pkg::BYTE_W-1:0] shadow_byte,
  output logic                        last_of_run,
  output sbrm_pkg::mem_req_t          mem_req,
  input  wire [sbrm_pkg::BYTE_W-1:0]  mem_rdata
);
  import sbrm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_READ  = 5'b00100,
    ST_LOAD  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  clr_addr;
  logic              op;
  logic [ADDR_W-1:0] addr;
  logic [LEN_W-1:0]  remaining;
  logic [BYTE_W-1:0] cur;

  logic [LEN_W-1:0]  len_sat;
  logic [BYTE_W-1:0] mask;
  logic [BYTE_W-1:0] upd;
  logic              fire;
  logic              run_end;
  logic              byte_end;

  assign in_ready = (state == ST_IDLE);
  assign len_sat  = (run_length > MAX_RUN) ? MAX_RUN : run_length;
  assign mask     = BYTE_W'(8'h80 >> addr[2:0]);
  assign upd      = (op == OP_LOAD) ? (cur & ~mask) : (cur | mask);
  assign fire     = (state == ST_EMIT) && (!out_valid || out_ready);
  assign run_end  = (remaining == LEN_W'(1));
  assign byte_end = run_end || (&addr[2:0]);

  always_comb begin
    mem_req.we    = (state == ST_CLEAR) || (fire && byte_end);
    mem_req.waddr = (state == ST_CLEAR) ? clr_addr : addr[ADDR_W-1:3];
    mem_req.wdata = (state == ST_CLEAR) ? '0 : upd;
    mem_req.re    = (state == ST_READ);
    mem_req.raddr = addr[ADDR_W-1:3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid && len_sat != '0) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (fire) begin
            if (run_end) begin
              state <= ST_IDLE;
            end else if (byte_end) begin
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op        <= req_type;
      addr      <= start_address;
      remaining <= len_sat;
    end
    if (state == ST_LOAD) begin
      cur <= mem_rdata;
    end
    if (fire) begin
      cur          <= upd;
      shadow_index <= addr[ADDR_W-1:3];
      shadow_byte  <= upd;
      last_of_run  <= run_end;
      addr         <= addr + ADDR_W'(1);
      remaining    <= remaining - LEN_W'(1);
    end
  end

  `SBRM_ASSERT_NOW(a_emit_has_work, state == ST_EMIT, remaining != '0, "empty run in emit")
  `SBRM_ASSERT_NOW(a_last_writes_back, fire && run_end, mem_req.we, "run ended without write")
  `SBRM_ASSERT_NEXT(a_last_goes_idle, fire && run_end,
                    state == ST_IDLE && out_valid && last_of_run, "run end not flagged")
  `SBRM_ASSERT_NOW(a_load_after_read, state == ST_LOAD,
                   $past(state) == ST_READ, "load without read")

endmodule

`default_nettype wire

### sv/shadow_bitmap_range_marker_top.sv
// After a request is accepted, the controller reads the shadow byte, loads it and then emits
// the first result word. Each shadow byte of a run costs one read and one write-back; a new
// request is accepted only once the run is done and the controller is back in idle.
// Reset: rst clears control state, then all 131072 shadow bytes of the store are cleared,
// one shadow byte per cycle, during which no request is accepted.
// ----------------------------------------------------------------------------
// Shadow bitmap range marker top level
// Sets or clears one bitmap bit per byte of a run and reports each updated byte.
// ----------------------------------------------------------------------------
`default_nettype none

module shadow_bitmap_range_marker_top (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         req_type,
  input  wire [sbrm_pkg::ADDR_W-1:0]  start_address,
  input  wire [sbrm_pkg::LEN_W-1:0]   run_length,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [sbrm_pkg::IDX_W-1:0]  shadow_index,
  output logic [sbrm_pkg::BYTE_W-1:0] shadow_byte,
  output logic                        last_of_run
);
  import sbrm_pkg::*;

  mem_req_t          mem_req;
  logic [BYTE_W-1:0] mem_rdata;

  sbrm_shadow_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  sbrm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .start_address (start_address),
    .run_length    (run_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .shadow_index  (shadow_index),
    .shadow_byte   (shadow_byte),
    .last_of_run   (last_of_run),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata)
  );

endmodule

`default_nettype wire
